[sv/pfb_pkg.sv]
// Package for the page-layout framebuffer pixel engine.
// Holds request and result types, operation and colour codes, and sizing defaults.
// Depends on nothing; the engine and the checker import it.
package pfb_pkg;

  // Default store geometry.
  localparam int MAX_WIDTH_DEF = 128;
  localparam int MAX_PAGES_DEF = 8;

  // Operation codes.
  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Colour codes.
  localparam logic [1:0] COLOR_BLACK   = 2'd0;
  localparam logic [1:0] COLOR_WHITE   = 2'd1;
  localparam logic [1:0] COLOR_INVERSE = 2'd2;

  // Fill bytes for a clear.
  localparam logic [7:0] FILL_WHITE = 8'hFF;
  localparam logic [7:0] FILL_BLACK = 8'h00;

  // Configuration register indexes.
  localparam int         CFG_IDX_W     = 1;
  localparam logic [0:0] CFG_WIDTH_PX  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT_PX = 1'b1;

  // Register reset values.
  localparam logic [7:0] WIDTH_PX_RST  = 8'd128;
  localparam logic [6:0] HEIGHT_PX_RST = 7'd64;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [1:0]         color;
    logic [2:0]         read_page;
    logic [6:0]         read_column;
  } pfb_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       clipped;
  } pfb_res_t;

endpackage

[sv/pfb_store.sv]
// Frame store memory: one write port and one read port with registered read data.
// Sized by its parameters only; uses no package items.
module pfb_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/page_framebuffer_pixel_engine.sv]
// Page-layout monochrome framebuffer pixel engine.
// Draw and read first address and read the store, then modify/write or capture the byte;
// the store's registered read data makes this split. Clipped draws and no-op requests finish on acceptance.
// Clear writes (H * W) / 8 store bytes, one store byte written per cycle.
// A finished result is registered into the output register, or waits in S_DONE while that register is stalled.
// Synchronous reset returns registers to 128 x 64 and empties the output; the store is not cleared.
module page_framebuffer_pixel_engine
  import pfb_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_PAGES = MAX_PAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  pfb_req_t             req_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output pfb_res_t             res_data
);

  localparam int AW_W   = $clog2(MAX_WIDTH + 1);
  localparam int AH_W   = $clog2(MAX_PAGES * 8 + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int DEPTH  = MAX_WIDTH * MAX_PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_CLR  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [7:0] width_px;
  logic [6:0] height_px;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_px  <= WIDTH_PX_RST;
      height_px <= HEIGHT_PX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH_PX:  width_px  <= cfg_data;
        CFG_HEIGHT_PX: height_px <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Active geometry, saturated to the store size.
  logic [8:0]      wmax;
  logic [7:0]      hmax;
  logic [AW_W-1:0] aw;
  logic [AH_W-1:0] ah;

  assign wmax = 9'(MAX_WIDTH);
  assign hmax = 8'(MAX_PAGES * 8);
  assign aw   = ({1'b0, width_px} > wmax) ? AW_W'(wmax) : AW_W'(width_px);
  assign ah   = ({1'b0, height_px} > hmax) ? AH_W'(hmax) : AH_W'(height_px);

  // Draw address, mask and clip test.
  logic [15:0]       x_u, y_u;
  logic              clip;
  logic [PG_W-1:0]   draw_page;
  logic [ADDR_W-1:0] draw_addr;
  logic [7:0]        draw_mask;
  logic              draw_colour_ok;

  assign x_u       = req_data.pixel_x;
  assign y_u       = req_data.pixel_y;
  assign clip      = x_u[15] || y_u[15] || (x_u >= 16'(aw)) || (y_u >= 16'(ah));
  assign draw_page = y_u[PG_W+2:3];
  assign draw_addr = ADDR_W'(ADDR_W'(draw_page) * ADDR_W'(aw) + ADDR_W'(x_u[COL_W-1:0]));
  assign draw_mask = 8'b1 << y_u[2:0];
  assign draw_colour_ok = (req_data.color == COLOR_BLACK) || (req_data.color == COLOR_WHITE) ||
                          (req_data.color == COLOR_INVERSE);

  // Read address and range test.
  logic              read_ok;
  logic [ADDR_W-1:0] read_addr;

  assign read_ok   = ({5'b0, req_data.read_page} < 8'(ah >> 3)) &&
                     (9'(req_data.read_column) < 9'(aw));
  assign read_addr = ADDR_W'(ADDR_W'(req_data.read_page) * ADDR_W'(aw) +
                     ADDR_W'(req_data.read_column));

  // Clear extent in bytes.
  logic [CNT_W-1:0] clr_count;
  logic             clr_colour_ok;

  assign clr_count     = CNT_W'((17'(ah) * 17'(aw)) >> 3);
  assign clr_colour_ok = (req_data.color == COLOR_BLACK) || (req_data.color == COLOR_WHITE);

  // Request context held across the memory access.
  logic [ADDR_W-1:0] addr_q;
  logic [7:0]        mask_q;
  logic [1:0]        color_q;
  logic              is_read_q;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] clr_last;
  logic [7:0]        fill_q;
  pfb_res_t          pend;

  // Memory ports.
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [7:0]        mem_rdata, mem_wdata;

  pfb_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  logic     acc, out_free;
  logic     fin, push;
  pfb_res_t fin_data, push_data;
  logic     ld_draw, ld_read, ld_clr;
  logic [7:0] mod_byte;

  assign acc       = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;
  assign req_stall = (state != S_IDLE);

  // Modified byte for a draw.
  always_comb begin
    case (color_q)
      COLOR_BLACK: mod_byte = mem_rdata & ~mask_q;
      COLOR_WHITE: mod_byte = mem_rdata | mask_q;
      default:     mod_byte = mem_rdata ^ mask_q;
    endcase
  end

  // Sequencer. Reads are issued only on acceptance and writes only in the modify and
  // clear states, so a read never meets a write to the same byte in one cycle.
  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = draw_addr;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = mod_byte;
    fin        = 1'b0;
    fin_data   = '0;
    ld_draw    = 1'b0;
    ld_read    = 1'b0;
    ld_clr     = 1'b0;
    push       = 1'b0;
    push_data  = pend;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (req_data.op)
            OP_DRAW: begin
              if (clip) begin
                fin              = 1'b1;
                fin_data.clipped = 1'b1;
              end else if (!draw_colour_ok) begin
                fin = 1'b1;
              end else begin
                mem_re     = 1'b1;
                ld_draw    = 1'b1;
                state_next = S_MOD;
              end
            end
            OP_CLEAR: begin
              if (clr_colour_ok && (clr_count != '0)) begin
                ld_clr     = 1'b1;
                state_next = S_CLR;
              end else begin
                fin = 1'b1;
              end
            end
            OP_READ: begin
              if (read_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = read_addr;
                ld_read    = 1'b1;
                state_next = S_MOD;
              end else begin
                fin = 1'b1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_MOD: begin
        fin = 1'b1;
        if (is_read_q) begin
          fin_data.read_data = mem_rdata;
        end else begin
          mem_we = 1'b1;
        end
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = fill_q;
        if (ptr == clr_last) begin
          fin = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // A finished request goes straight to the output register when it is free.
    if (fin) begin
      if (out_free) begin
        push       = 1'b1;
        push_data  = fin_data;
        state_next = S_IDLE;
      end else begin
        state_next = S_DONE;
      end
    end
  end

  // Control state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload and context registers.
  always_ff @(posedge clk) begin
    if (push) begin
      res_data <= push_data;
    end
    if (fin && !out_free) begin
      pend <= fin_data;
    end
    if (ld_draw) begin
      addr_q    <= draw_addr;
      mask_q    <= draw_mask;
      color_q   <= req_data.color;
      is_read_q <= 1'b0;
    end
    if (ld_read) begin
      is_read_q <= 1'b1;
    end
    if (ld_clr) begin
      ptr      <= '0;
      clr_last <= ADDR_W'(clr_count - CNT_W'(1));
      fill_q   <= (req_data.color == COLOR_WHITE) ? FILL_WHITE : FILL_BLACK;
    end else if (state == S_CLR) begin
      ptr <= ptr + ADDR_W'(1);
    end
  end

endmodule

[sv/pfb_checker.sv]
// Port-level checker for the page framebuffer pixel engine, with its bind statement.
// Depends on pfb_pkg for the payload types.
module pfb_checker
  import pfb_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     res_valid,
  input logic     res_stall,
  input pfb_res_t res_data
);

  // A stalled result stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(res_data))
    else $error("result payload changed while stalled");

  // Only a draw can be clipped, and a draw returns no data.
  a_clip_no_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.clipped |-> res_data.read_data == 8'h00)
    else $error("clipped result carries read data");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered after reset");

endmodule

bind page_framebuffer_pixel_engine pfb_checker u_pfb_checker (.*);
